// ===== sv/crg_pkg.sv =====
// Package for the Cauchy random generator.
// Holds types, constants, state encodings and the arctangent table.
// No dependencies.
package crg_pkg;

  localparam int unsigned MT_N = 624;
  localparam int unsigned MT_M = 397;
  localparam int unsigned MT_AW = 10;
  localparam logic [31:0] MT_MAG = 32'h9908B0DF;
  localparam logic [31:0] SEED_MULT = 32'd1812433253;
  localparam logic [31:0] RESET_SEED = 32'd5489;
  localparam logic [31:0] ALPHA_RESET = 32'd65536;
  localparam int unsigned OUT_W = 48;
  localparam int unsigned DEF_OUTPUT_FRAC_BITS = 16;
  localparam int unsigned DEF_CORDIC_STEPS = 32;
  localparam int unsigned ATAN_LEN = 40;
  localparam int unsigned JOB_DEPTH = 2;

  typedef enum logic {
    CMD_GENERATE = 1'b0,
    CMD_RESEED   = 1'b1
  } cmd_t;

  typedef struct packed {
    logic        command;
    logic [31:0] new_seed;
  } in_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] sample_value;
    logic [31:0]             draw_count;
    logic                    alpha_zero;
    logic                    saturated;
  } out_t;

  typedef struct packed {
    logic [31:0] word;
    logic [31:0] count;
  } job_t;

  typedef enum logic [3:0] {
    F_SEED0, F_SEED, F_IDLE, F_TW_PRE, F_TW_LD, F_TW_RD, F_TW_WR, F_DR_RD, F_DR_WR
  } front_state_t;

  typedef enum logic [2:0] {
    B_IDLE, B_ROT, B_MUL, B_LOAD, B_DIV, B_FIN, B_DONE
  } back_state_t;

  function automatic logic [31:0] atan_entry(input logic [5:0] idx);
    logic [31:0] v;
    case (idx)
      6'd0:  v = 32'd1073741824;
      6'd1:  v = 32'd633866811;
      6'd2:  v = 32'd334917815;
      6'd3:  v = 32'd170009512;
      6'd4:  v = 32'd85334662;
      6'd5:  v = 32'd42708931;
      6'd6:  v = 32'd21359677;
      6'd7:  v = 32'd10680490;
      6'd8:  v = 32'd5340327;
      6'd9:  v = 32'd2670173;
      6'd10: v = 32'd1335088;
      6'd11: v = 32'd667544;
      6'd12: v = 32'd333772;
      6'd13: v = 32'd166886;
      6'd14: v = 32'd83443;
      6'd15: v = 32'd41722;
      6'd16: v = 32'd20861;
      6'd17: v = 32'd10430;
      6'd18: v = 32'd5215;
      6'd19: v = 32'd2608;
      6'd20: v = 32'd1304;
      6'd21: v = 32'd652;
      6'd22: v = 32'd326;
      6'd23: v = 32'd163;
      6'd24: v = 32'd81;
      6'd25: v = 32'd41;
      6'd26: v = 32'd20;
      6'd27: v = 32'd10;
      6'd28: v = 32'd5;
      6'd29: v = 32'd3;
      6'd30: v = 32'd1;
      6'd31: v = 32'd1;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

// ===== sv/crg_front.sv =====
// Front end: accepts commands, seeds and twists the MT19937 state, draws words.
// Depends on crg_pkg. Pushes drawn words with their draw count into the job queue.
module crg_front
  import crg_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_push,
  output logic in_full,
  input  in_t  in_data,
  input  logic q_full,
  output logic q_push,
  output job_t q_data
);

  front_state_t state_r, state_nxt;
  logic [31:0] seed_r, seed_nxt;
  logic [31:0] count_r, count_nxt;
  logic [MT_AW-1:0] idx_r, idx_nxt;
  logic [MT_AW-1:0] k_r, k_nxt;
  logic [31:0] p_r, p_nxt;
  logic [31:0] hold_r, hold_nxt;

  logic [31:0] mem [MT_N];
  logic [31:0] rda_r, rdb_r;
  logic [MT_AW-1:0] ra, rb, wa;
  logic [31:0] wd;
  logic we;

  logic accept;
  logic [31:0] seed_val, tw_y, tw_v;

  function automatic logic [31:0] temper(input logic [31:0] w);
    logic [31:0] t;
    t = w ^ (w >> 11);
    t = t ^ ((t << 7) & 32'h9D2C5680);
    t = t ^ ((t << 15) & 32'hEFC60000);
    t = t ^ (t >> 18);
    return t;
  endfunction

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rda_r <= mem[ra];
    rdb_r <= mem[rb];
  end

  assign accept = in_push && !in_full;
  assign in_full = (state_r != F_IDLE) || q_full;
  assign seed_val = 32'(SEED_MULT * (p_r ^ (p_r >> 30))) + {{(32-MT_AW){1'b0}}, k_r};
  assign tw_y = {hold_r[31], rda_r[30:0]};
  assign tw_v = rdb_r ^ (tw_y >> 1) ^ (tw_y[0] ? MT_MAG : 32'd0);

  always_comb begin
    state_nxt = state_r;
    seed_nxt = seed_r;
    count_nxt = count_r;
    idx_nxt = idx_r;
    k_nxt = k_r;
    p_nxt = p_r;
    hold_nxt = hold_r;
    ra = idx_r;
    rb = k_r;
    wa = k_r;
    wd = tw_v;
    we = 1'b0;
    q_push = 1'b0;
    q_data.word = temper(rda_r);
    q_data.count = count_r;
    case (state_r)
      F_SEED0: begin
        we = 1'b1;
        wa = '0;
        wd = seed_r;
        p_nxt = seed_r;
        k_nxt = MT_AW'(1);
        state_nxt = F_SEED;
      end
      F_SEED: begin
        we = 1'b1;
        wd = seed_val;
        p_nxt = seed_val;
        if (k_r == MT_AW'(MT_N - 1)) begin
          idx_nxt = MT_AW'(MT_N);
          state_nxt = F_IDLE;
        end else begin
          k_nxt = k_r + MT_AW'(1);
        end
      end
      F_IDLE: begin
        if (accept) begin
          if (in_data.command == CMD_RESEED) begin
            if (in_data.new_seed != seed_r) begin
              seed_nxt = in_data.new_seed;
              count_nxt = '0;
              state_nxt = F_SEED0;
            end
          end else begin
            count_nxt = count_r + 32'd1;
            state_nxt = (idx_r >= MT_AW'(MT_N)) ? F_TW_PRE : F_DR_RD;
          end
        end
      end
      F_TW_PRE: begin
        ra = '0;
        k_nxt = '0;
        state_nxt = F_TW_LD;
      end
      F_TW_LD: begin
        hold_nxt = rda_r;
        state_nxt = F_TW_RD;
      end
      F_TW_RD: begin
        ra = (k_r == MT_AW'(MT_N - 1)) ? '0 : k_r + MT_AW'(1);
        rb = (k_r >= MT_AW'(MT_N - MT_M)) ? k_r - MT_AW'(MT_N - MT_M) : k_r + MT_AW'(MT_M);
        state_nxt = F_TW_WR;
      end
      F_TW_WR: begin
        we = 1'b1;
        hold_nxt = rda_r;
        if (k_r == MT_AW'(MT_N - 1)) begin
          idx_nxt = '0;
          state_nxt = F_DR_RD;
        end else begin
          k_nxt = k_r + MT_AW'(1);
          state_nxt = F_TW_RD;
        end
      end
      F_DR_RD: begin
        ra = idx_r;
        state_nxt = F_DR_WR;
      end
      F_DR_WR: begin
        q_push = 1'b1;
        idx_nxt = idx_r + MT_AW'(1);
        state_nxt = F_IDLE;
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_SEED0;
      seed_r <= RESET_SEED;
      count_r <= '0;
      idx_r <= MT_AW'(MT_N);
    end else begin
      state_r <= state_nxt;
      seed_r <= seed_nxt;
      count_r <= count_nxt;
      idx_r <= idx_nxt;
    end
    k_r <= k_nxt;
    p_r <= p_nxt;
    hold_r <= hold_nxt;
  end

endmodule

// ===== sv/crg_queue.sv =====
// Short job queue between front and back end.
// Depends on crg_pkg for the job type and depth.
module crg_queue
  import crg_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_data,
  output logic full,
  input  logic pop,
  output logic empty,
  output job_t pop_data
);

  localparam int unsigned PW = (JOB_DEPTH > 1) ? $clog2(JOB_DEPTH) : 1;
  localparam int unsigned CW = $clog2(JOB_DEPTH + 1);

  job_t entry_r [JOB_DEPTH];
  logic [PW-1:0] wp_r, rp_r;
  logic [CW-1:0] cnt_r;

  assign full = (cnt_r == CW'(JOB_DEPTH));
  assign empty = (cnt_r == '0);
  assign pop_data = entry_r[rp_r];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      entry_r[wp_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (push && !full) begin
        wp_r <= (wp_r == PW'(JOB_DEPTH - 1)) ? '0 : wp_r + PW'(1);
      end
      if (pop && !empty) begin
        rp_r <= (rp_r == PW'(JOB_DEPTH - 1)) ? '0 : rp_r + PW'(1);
      end
      cnt_r <= cnt_r + CW'(push && !full) - CW'(pop && !empty);
    end
  end

endmodule

// ===== sv/crg_back.sv =====
// Back end: CORDIC tangent, alpha multiply, bit-serial divide, saturation.
// Depends on crg_pkg. Holds the output register for the result channel.
module crg_back
  import crg_pkg::*;
#(
  parameter int unsigned OUTPUT_FRAC_BITS = DEF_OUTPUT_FRAC_BITS,
  parameter int unsigned CORDIC_STEPS = DEF_CORDIC_STEPS
)(
  input  logic        clk,
  input  logic        rst_n,
  input  logic [31:0] alpha,
  input  logic        q_empty,
  output logic        q_pop,
  input  job_t        q_data,
  output logic        out_empty,
  input  logic        out_pop,
  output out_t        out_data
);

  localparam int unsigned SHL = (OUTPUT_FRAC_BITS > 16) ? OUTPUT_FRAC_BITS - 16 : 0;
  localparam int unsigned SHR = (OUTPUT_FRAC_BITS < 16) ? 16 - OUTPUT_FRAC_BITS : 0;
  localparam int unsigned NW = 64 + SHL;
  localparam int unsigned DW = 33;
  localparam logic [OUT_W:0] POS_LIM = {2'b00, {(OUT_W-1){1'b1}}};
  localparam logic [OUT_W:0] NEG_LIM = {2'b01, {(OUT_W-1){1'b0}}};

  back_state_t state_r, state_nxt;
  logic signed [33:0] x_r, y_r, z_r;
  logic [6:0] cnt_r;
  logic neg_r, pole_r;
  logic [31:0] count_r;
  logic [63:0] prod_r;
  logic [DW-1:0] d_r;
  logic [NW-1:0] n_r;
  logic [DW-1:0] rem_r;
  logic [OUT_W-1:0] q_r;
  logic ovf_r;
  out_t pend_r;
  out_t res_r;
  logic out_valid_r;

  logic [5:0] step;
  logic signed [33:0] dx, dy, atz;
  logic [31:0] amag, ym;
  logic [DW:0] rem_s;
  logic [OUT_W:0] lim, qx;
  logic sat;
  logic [OUT_W-1:0] mag;
  logic load_out;

  assign step = cnt_r[5:0];
  assign dx = y_r >>> step;
  assign dy = x_r >>> step;
  assign atz = {2'b00, atan_entry(step)};
  assign amag = alpha[31] ? (~alpha + 32'd1) : alpha;
  assign ym = y_r[33] ? 32'(-y_r) : y_r[31:0];
  assign rem_s = {rem_r, n_r[NW-1]};
  assign lim = neg_r ? NEG_LIM : POS_LIM;
  assign qx = {1'b0, q_r};
  assign sat = pole_r || ovf_r || (qx > lim);
  assign mag = sat ? lim[OUT_W-1:0] : q_r;
  assign q_pop = (state_r == B_IDLE) && !q_empty;
  assign load_out = (state_r == B_DONE) && (!out_valid_r || out_pop);
  assign out_empty = !out_valid_r;
  assign out_data = res_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      B_IDLE: begin
        if (!q_empty) begin
          state_nxt = (alpha == '0) ? B_DONE : B_ROT;
        end
      end
      B_ROT: begin
        if (cnt_r == 7'(CORDIC_STEPS - 1)) begin
          state_nxt = B_MUL;
        end
      end
      B_MUL: state_nxt = (x_r <= 0) ? B_FIN : B_LOAD;
      B_LOAD: state_nxt = B_DIV;
      B_DIV: begin
        if (cnt_r == 7'(NW - 1)) begin
          state_nxt = B_FIN;
        end
      end
      B_FIN: state_nxt = B_DONE;
      B_DONE: begin
        if (load_out) begin
          state_nxt = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state_r)
      B_IDLE: begin
        count_r <= q_data.count;
        cnt_r <= '0;
        pole_r <= 1'b0;
        x_r <= 34'sd1 <<< 30;
        y_r <= '0;
        if (q_data.word > 32'h80000000) begin
          z_r <= {2'b00, 32'(33'h100000000 - {1'b0, q_data.word})};
          neg_r <= ~alpha[31];
        end else begin
          z_r <= {2'b00, q_data.word};
          neg_r <= alpha[31];
        end
        pend_r.sample_value <= '0;
        pend_r.draw_count <= q_data.count;
        pend_r.alpha_zero <= 1'b1;
        pend_r.saturated <= 1'b0;
      end
      B_ROT: begin
        cnt_r <= cnt_r + 7'd1;
        if (!z_r[33]) begin
          x_r <= x_r - dx;
          y_r <= y_r + dy;
          z_r <= z_r - atz;
        end else begin
          x_r <= x_r + dx;
          y_r <= y_r - dy;
          z_r <= z_r + atz;
        end
      end
      B_MUL: begin
        if (x_r <= 0) begin
          pole_r <= 1'b1;
        end else begin
          neg_r <= neg_r ^ y_r[33];
        end
        prod_r <= 64'(amag) * 64'(ym);
        d_r <= x_r[DW-1:0];
      end
      B_LOAD: begin
        n_r <= (NW'(prod_r) << SHL) >> SHR;
        rem_r <= '0;
        q_r <= '0;
        ovf_r <= 1'b0;
        cnt_r <= '0;
      end
      B_DIV: begin
        cnt_r <= cnt_r + 7'd1;
        n_r <= n_r << 1;
        ovf_r <= ovf_r | q_r[OUT_W-1];
        if (rem_s >= {1'b0, d_r}) begin
          rem_r <= DW'(rem_s - {1'b0, d_r});
          q_r <= {q_r[OUT_W-2:0], 1'b1};
        end else begin
          rem_r <= rem_s[DW-1:0];
          q_r <= {q_r[OUT_W-2:0], 1'b0};
        end
      end
      B_FIN: begin
        pend_r.sample_value <= neg_r ? -$signed(mag) : $signed(mag);
        pend_r.draw_count <= count_r;
        pend_r.alpha_zero <= 1'b0;
        pend_r.saturated <= sat;
      end
      B_DONE: begin
        if (load_out) begin
          res_r <= pend_r;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

// ===== sv/cauchy_random_generator.sv =====
// Top level of the Cauchy random generator: front end, job queue, back end.
// Depends on crg_pkg, crg_front, crg_queue and crg_back.
//
//   channel  ports                          transfer when
//   input    in_push, in_full, in_data      in_push && !in_full
//   result   out_pop, out_empty, out_data   out_pop && !out_empty
//   config   cfg_we, cfg_wdata              cfg_we
//
// A generate draws one word in the front end, first twisting the whole state on every 624th draw
// (the twister memory gives two reads a cycle); a reseed with a new seed seeds the state anew.
// The back end runs an iterative CORDIC and then a one-bit-a-step divider.
// After reset the twister is seeded with in_full high.
// A two-entry queue lets the front end draw while the back end waits on out_pop.
module cauchy_random_generator
  import crg_pkg::*;
#(
  parameter int unsigned OUTPUT_FRAC_BITS = DEF_OUTPUT_FRAC_BITS,
  parameter int unsigned CORDIC_STEPS = DEF_CORDIC_STEPS
)(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  in_t         in_data,
  output logic        out_empty,
  input  logic        out_pop,
  output out_t        out_data,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata
);

  logic [31:0] alpha_r;
  logic q_push, q_full, q_pop, q_empty;
  job_t q_in, q_out;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r <= ALPHA_RESET;
    end else if (cfg_we) begin
      alpha_r <= cfg_wdata;
    end
  end

  crg_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_push (in_push),
    .in_full (in_full),
    .in_data (in_data),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_data  (q_in)
  );

  crg_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .pop_data  (q_out)
  );

  crg_back #(
    .OUTPUT_FRAC_BITS (OUTPUT_FRAC_BITS),
    .CORDIC_STEPS     (CORDIC_STEPS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .alpha     (alpha_r),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .q_data    (q_out),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

endmodule

// ===== sv/crg_checker.sv =====
// Port-level checks for the Cauchy random generator, bound to the top level.
// Depends on crg_pkg.
module crg_checker
  import crg_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic in_push,
  input logic in_full,
  input in_t  in_data,
  input logic out_empty,
  input logic out_pop,
  input out_t out_data
);

  localparam logic signed [OUT_W-1:0] MAX_V = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic signed [OUT_W-1:0] MIN_V = {1'b1, {(OUT_W-1){1'b0}}};

  a_reset_full: assert property (@(posedge clk) !rst_n |=> in_full)
    else $error("input not held off after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_pop |=> !out_empty && $stable(out_data))
    else $error("waiting result changed");

  a_gen_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_push && !in_full && (in_data.command == CMD_GENERATE) |=> in_full)
    else $error("generate transfer did not occupy front end");

  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && out_data.alpha_zero |-> (out_data.sample_value == '0) && !out_data.saturated)
    else $error("zero alpha gave non-zero result");

  a_sat: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && out_data.saturated |->
      (out_data.sample_value == MAX_V) || (out_data.sample_value == MIN_V))
    else $error("saturated result not at a limit");

endmodule

bind cauchy_random_generator crg_checker u_crg_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_push   (in_push),
  .in_full   (in_full),
  .in_data   (in_data),
  .out_empty (out_empty),
  .out_pop   (out_pop),
  .out_data  (out_data)
);

// ===== verif/tb_cauchy_random_generator.sv =====
// Testbench for cauchy_random_generator: directed and random generate/reseed traffic.
// Predicts each result with a local twister, CORDIC tangent and scaling, then checks it.
// Depends on crg_pkg and the cauchy_random_generator RTL.
module tb_cauchy_random_generator;
  import crg_pkg::*;

  localparam int unsigned LIMIT = 3000000;
  localparam int unsigned SETTLE = 1500;

  logic clk;
  logic rst_n;
  logic in_push;
  logic in_full;
  in_t in_data;
  logic out_empty;
  logic out_pop;
  out_t out_data;
  logic cfg_we;
  logic [31:0] cfg_wdata;

  cauchy_random_generator uut (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_full(in_full), .in_data(in_data),
    .out_empty(out_empty), .out_pop(out_pop), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  localparam longint ARCTAN_UNITS [ATAN_LEN] = '{
    1073741824, 633866811, 334917815, 170009512, 85334662,
    42708931, 21359677, 10680490, 5340327, 2670173,
    1335088, 667544, 333772, 166886, 83443,
    41722, 20861, 10430, 5215, 2608,
    1304, 652, 326, 163, 81,
    41, 20, 10, 5, 3,
    1, 1, 0, 0, 0, 0, 0, 0, 0, 0
  };

  bit [31:0] mt_words [MT_N];
  int unsigned mt_pos;
  bit [31:0] seed_held;
  bit [31:0] draws;
  bit [31:0] alpha;

  out_t pending_samples [$];
  int unsigned errors;
  int unsigned cycles;
  int unsigned burst_left;
  int unsigned hold_off;

  initial begin
    clk = 1'b0;
    forever begin
      #5 clk = 1'b1;
      #5 clk = 1'b0;
    end
  end

  function automatic void mt_seed(input bit [31:0] s);
    bit [31:0] p;
    mt_words[0] = s;
    for (int unsigned i = 1; i < MT_N; i++) begin
      p = mt_words[i-1];
      mt_words[i] = 32'd1812433253 * (p ^ (p >> 30)) + i;
    end
    mt_pos = MT_N;
  endfunction

  function automatic bit [31:0] mt_draw();
    bit [31:0] w;
    bit [31:0] v;
    if (mt_pos >= MT_N) begin
      for (int unsigned k = 0; k < MT_N; k++) begin
        w = (mt_words[k] & 32'h8000_0000) | (mt_words[(k + 1) % MT_N] & 32'h7FFF_FFFF);
        v = mt_words[(k + MT_M) % MT_N] ^ (w >> 1);
        if (w[0]) v ^= 32'h9908_B0DF;
        mt_words[k] = v;
      end
      mt_pos = 0;
    end
    w = mt_words[mt_pos];
    mt_pos++;
    w ^= w >> 11;
    w ^= (w << 7) & 32'h9D2C_5680;
    w ^= (w << 15) & 32'hEFC6_0000;
    w ^= w >> 18;
    return w;
  endfunction

  function automatic out_t cauchy_sample();
    bit [31:0] r;
    longint x, y, z, dx, dy;
    longint unsigned rr, amag, ym, n, d, q, mag, lim;
    bit neg, sat;
    out_t o;
    draws++;
    r = mt_draw();
    o = '0;
    o.draw_count = draws;
    if (alpha == 32'd0) begin
      o.alpha_zero = 1'b1;
      return o;
    end
    amag = alpha[31] ? {32'd0, -alpha} : {32'd0, alpha};
    neg = alpha[31];
    if (r > 32'h8000_0000) begin
      rr = 64'h1_0000_0000 - r;
      neg = !neg;
    end else begin
      rr = r;
    end
    x = longint'(1) << 30;
    y = 0;
    z = longint'(rr);
    for (int i = 0; i < DEF_CORDIC_STEPS && i < ATAN_LEN; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= ARCTAN_UNITS[i];
      end else begin
        x += dx; y -= dy; z += ARCTAN_UNITS[i];
      end
    end
    sat = 1'b0;
    mag = 0;
    if (x <= 0) begin
      sat = 1'b1;
    end else begin
      d = longint'(x);
      if (y < 0) begin
        ym = -y;
        neg = !neg;
      end else begin
        ym = y;
      end
      n = amag * ym;
      q = n / d;
      if (q >= (64'd1 << 48)) sat = 1'b1;
      else mag = q;
    end
    lim = neg ? (64'd1 << 47) : ((64'd1 << 47) - 1);
    if (!sat && mag > lim) sat = 1'b1;
    if (sat) mag = lim;
    o.sample_value = neg ? -mag[47:0] : mag[47:0];
    o.saturated = sat;
    return o;
  endfunction

  task automatic send_item(input cmd_t cmd, input bit [31:0] seed);
    if (burst_left == 0) begin
      in_push <= 1'b0;
      repeat ($urandom_range(6)) @(posedge clk);
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    in_push <= 1'b1;
    in_data <= '{command: cmd, new_seed: seed};
    do @(negedge clk); while (in_full);
    if (cmd == CMD_RESEED) begin
      if (seed != seed_held) begin
        seed_held = seed;
        mt_seed(seed);
        draws = 0;
      end
    end else begin
      pending_samples.push_back(cauchy_sample());
    end
    @(posedge clk);
  endtask

  task automatic drain();
    in_push <= 1'b0;
    burst_left = 0;
    while (pending_samples.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_alpha(input bit [31:0] v);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    alpha = v;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic test_reset_scale();
    repeat (4) send_item(CMD_GENERATE, $urandom);
  endtask

  task automatic test_alpha_extremes();
    bit [31:0] vals [6] = '{32'd0, 32'h8000_0000, 32'h7FFF_FFFF, 32'd1, 32'hFFFF_FFFF,
                            32'hFFFF_0000};
    foreach (vals[i]) begin
      write_alpha(vals[i]);
      repeat (2) send_item(CMD_GENERATE, 32'd0);
    end
    write_alpha(ALPHA_RESET);
  endtask

  task automatic test_reseed();
    send_item(CMD_RESEED, seed_held);
    send_item(CMD_GENERATE, 32'd0);
    send_item(CMD_RESEED, 32'd0);
    send_item(CMD_GENERATE, 32'hFFFF_FFFF);
    send_item(CMD_RESEED, 32'hFFFF_FFFF);
    send_item(CMD_GENERATE, 32'd0);
    send_item(CMD_RESEED, RESET_SEED);
    send_item(CMD_GENERATE, 32'd0);
  endtask

  task automatic test_backpressure();
    hold_off = 400;
    repeat (10) send_item(CMD_GENERATE, $urandom);
  endtask

  task automatic test_random();
    bit [31:0] a;
    for (int ph = 0; ph < 6; ph++) begin
      case ($urandom_range(3))
        0: a = $urandom;
        1: a = 32'h8000_0000 + $urandom_range(1);
        default: a = $urandom_range(32'h0010_0000) - 32'h0008_0000;
      endcase
      write_alpha(a);
      repeat (310) begin
        if ($urandom_range(99) < 5) begin
          send_item(CMD_RESEED, $urandom_range(1) ? seed_held : $urandom);
        end else begin
          send_item(CMD_GENERATE, $urandom);
        end
      end
    end
  endtask

  // receiver: pop on a pattern of its own, hold for the requested stretch
  initial begin
    int unsigned mode;
    int unsigned mode_left;
    mode = 0;
    mode_left = 0;
    out_pop = 1'b0;
    forever begin
      @(posedge clk);
      if (mode_left == 0) begin
        mode = $urandom_range(3);
        mode_left = $urandom_range(10, 80);
      end
      mode_left--;
      if (hold_off != 0) begin
        hold_off--;
        out_pop <= 1'b0;
      end else begin
        case (mode)
          0: out_pop <= 1'b1;
          1: out_pop <= $urandom_range(1);
          2: out_pop <= ($urandom_range(7) == 0);
          default: out_pop <= ($urandom_range(3) != 0);
        endcase
      end
    end
  end

  // check each result transfer against the oldest prediction
  initial begin
    out_t want;
    forever begin
      @(negedge clk);
      if (rst_n && out_pop && !out_empty) begin
        if (pending_samples.size() == 0) begin
          $error("result transfer with nothing predicted");
          errors++;
        end else begin
          want = pending_samples.pop_front();
          if (out_data.sample_value !== want.sample_value) begin
            $error("sample_value expected %0d actual %0d", want.sample_value,
                   out_data.sample_value);
            errors++;
          end
          if (out_data.draw_count !== want.draw_count) begin
            $error("draw_count expected %0d actual %0d", want.draw_count, out_data.draw_count);
            errors++;
          end
          if (out_data.alpha_zero !== want.alpha_zero) begin
            $error("alpha_zero expected %0b actual %0b", want.alpha_zero, out_data.alpha_zero);
            errors++;
          end
          if (out_data.saturated !== want.saturated) begin
            $error("saturated expected %0b actual %0b", want.saturated, out_data.saturated);
            errors++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    cycles = 0;
    errors = 0;
    burst_left = 0;
    hold_off = 0;
    rst_n = 1'b0;
    in_push = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    alpha = ALPHA_RESET;
    seed_held = RESET_SEED;
    draws = 0;
    mt_seed(RESET_SEED);
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_scale();
    test_alpha_extremes();
    test_reseed();
    test_backpressure();
    test_random();
    drain();
    if (errors == 0 && pending_samples.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
